// ===== rtl/max_line_hull_container_macros.svh =====
// Assertion macros used by the line hull container top level.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef MAX_LINE_HULL_CONTAINER_MACROS_SVH
`define MAX_LINE_HULL_CONTAINER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MLH_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MLH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mlh_pkg.sv =====
// Shared types and constants of the line hull container.
// No dependencies; mlh_front, mlh_engine and the top level import this package.
package mlh_pkg;

  localparam int SLOPE_W     = 32;
  localparam int ICPT_W      = 48;
  localparam int POINT_W     = 32;
  localparam int VALUE_W     = 64;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  intercept;
  } line_t;

  typedef struct packed {
    op_t                       op;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  intercept;
    logic signed [POINT_W-1:0] query_point;
  } cmd_t;

endpackage

// ===== rtl/mlh_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Field widths follow the constants of mlh_pkg.
interface mlh_item_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] slope;
  logic signed [47:0] intercept;
  logic signed [31:0] query_point;

  modport source(output valid, mode, slope, intercept, query_point, input ready);
  modport sink(input valid, mode, slope, intercept, query_point, output ready);
endinterface

interface mlh_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] best_value;
  logic [1:0]         status;

  modport source(output valid, best_value, status, input ready);
  modport sink(input valid, best_value, status, output ready);
endinterface

// ===== rtl/mlh_front.sv =====
// Request front end: decodes incoming requests and queues them for the engine.
// Depends on mlh_pkg and mlh_item_if.
module mlh_front (
  input  logic          clk,
  input  logic          rst,
  mlh_item_if.sink      items,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output mlh_pkg::cmd_t cmd
);
  import mlh_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;
  cmd_t             decoded;

  always_comb begin
    decoded.op          = items.mode ? OP_QUERY : OP_INSERT;
    decoded.slope       = items.slope;
    decoded.intercept   = items.intercept;
    decoded.query_point = items.query_point;
  end

  assign items.ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign push        = items.valid && items.ready;
  assign cmd_valid   = (fill != '0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mlh_engine.sv =====
// Hull engine: stores the envelope lines in a memory and runs inserts and queries.
// Depends on mlh_pkg and mlh_result_if.
module mlh_engine #(
  parameter int CAPACITY = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  mlh_pkg::cmd_t                    cmd,
  mlh_result_if.source                     results,
  output logic [$clog2(CAPACITY + 1)-1:0]  line_count
);
  import mlh_pkg::*;

  localparam int AW      = $clog2(CAPACITY);
  localparam int CW      = $clog2(CAPACITY + 1);
  localparam int DIFF_W  = ICPT_W + 1;
  localparam int SDIFF_W = SLOPE_W + 1;
  localparam int SPLIT   = 25;
  localparam int PART_W  = SPLIT + 1;
  localparam int MPROD_W = PART_W + SDIFF_W;
  localparam int WPROD_W = DIFF_W + SDIFF_W;

  typedef enum logic [4:0] {
    S_IDLE, S_Q_RD, S_Q_MUL, S_Q_ADD, S_F_RD, S_F_CMP, S_N_CHK, S_RM_RD, S_RM_WR,
    S_G_RD0, S_G_RD1, S_G_GOT, S_U_DIFF, S_U_MUL, S_U_CMP, S_N_DEC, S_IN_RD,
    S_IN_WR, S_IN_PUT, S_R_CHK, S_R_DEC, S_L_CHK, S_L_DEC, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    FK_NEIGH, FK_RIGHT, FK_LEFT
  } fetch_t;

  line_t mem [CAPACITY];
  line_t rdata;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  line_t         wdata;

  state_t  state;
  state_t  ret;
  fetch_t  fkind;
  logic [CW-1:0] cnt;
  logic [CW-1:0] p;
  logic [CW-1:0] j;
  logic [CW-1:0] i;
  logic [AW-1:0] fa0;
  logic [AW-1:0] fa1;
  line_t   nl;
  line_t   ul;
  line_t   um;
  line_t   ur;
  logic signed [POINT_W-1:0] x;
  logic signed [VALUE_W-1:0] prod;
  logic signed [ICPT_W-1:0]  qb;
  logic signed [VALUE_W-1:0] qv;
  logic signed [VALUE_W-1:0] fbest;
  status_t fstat;
  logic signed [DIFF_W-1:0]  d1;
  logic signed [DIFF_W-1:0]  d2;
  logic signed [SDIFF_W-1:0] e1;
  logic signed [SDIFF_W-1:0] e2;
  logic [2:0] k;
  logic signed [PART_W-1:0]  mul_a;
  logic signed [SDIFF_W-1:0] mul_b;
  logic signed [MPROD_W-1:0] mul_p;
  logic signed [MPROD_W-1:0] mres;
  logic signed [WPROD_W-1:0] mres_w;
  logic signed [WPROD_W-1:0] mres_hi;
  logic signed [WPROD_W-1:0] acc1;
  logic signed [WPROD_W-1:0] acc2;
  logic    useless_f;
  logic    ov;
  logic signed [VALUE_W-1:0] obest;
  status_t ostat;

  assign cmd_ready          = (state == S_IDLE);
  assign line_count         = cnt;
  assign results.valid      = ov;
  assign results.best_value = obest;
  assign results.status     = ostat;

  // Memory: one write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    unique case (state)
      S_Q_RD:   raddr = i[AW-1:0];
      S_F_RD:   raddr = p[AW-1:0];
      S_RM_RD:  raddr = AW'(j + 1'b1);
      S_RM_WR: begin
        we    = 1'b1;
        waddr = j[AW-1:0];
      end
      S_G_RD0:  raddr = fa0;
      S_G_RD1:  raddr = fa1;
      S_IN_RD:  raddr = AW'(j - 1'b1);
      S_IN_WR: begin
        we    = 1'b1;
        waddr = j[AW-1:0];
      end
      S_IN_PUT: begin
        we    = 1'b1;
        waddr = p[AW-1:0];
        wdata = nl;
      end
      default: raddr = '0;
    endcase
  end

  // Each wide cross product is split into a low unsigned part and a high signed part.
  always_comb begin
    case (k[1:0])
      2'd0:    mul_a = $signed({1'b0, d1[SPLIT-1:0]});
      2'd1:    mul_a = $signed({{(PART_W-DIFF_W+SPLIT){d1[DIFF_W-1]}}, d1[DIFF_W-1:SPLIT]});
      2'd2:    mul_a = $signed({1'b0, d2[SPLIT-1:0]});
      default: mul_a = $signed({{(PART_W-DIFF_W+SPLIT){d2[DIFF_W-1]}}, d2[DIFF_W-1:SPLIT]});
    endcase
    mul_b = k[1] ? e2 : e1;
  end

  assign mul_p   = mul_a * mul_b;
  assign mres_w  = $signed({{(WPROD_W-MPROD_W){mres[MPROD_W-1]}}, mres});
  assign mres_hi = $signed({mres_w[WPROD_W-SPLIT-1:0], {SPLIT{1'b0}}});
  assign qv      = prod + $signed({{(VALUE_W-ICPT_W){qb[ICPT_W-1]}}, qb});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      ov    <= 1'b0;
    end else begin
      if (results.ready && state != S_EMIT) begin
        ov <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            fbest <= '0;
            x     <= cmd.query_point;
            nl.slope     <= cmd.slope;
            nl.intercept <= cmd.intercept;
            if (cmd.op == OP_QUERY) begin
              if (cnt == '0) begin
                fstat <= ST_EMPTY;
                state <= S_EMIT;
              end else begin
                i     <= '0;
                state <= S_Q_RD;
              end
            end else if (cnt == CW'(CAPACITY)) begin
              fstat <= ST_FULL;
              state <= S_EMIT;
            end else begin
              p     <= '0;
              state <= S_F_RD;
            end
          end
        end
        S_Q_RD: state <= S_Q_MUL;
        S_Q_MUL: begin
          prod  <= $signed(rdata.slope) * x;
          qb    <= rdata.intercept;
          state <= S_Q_ADD;
        end
        S_Q_ADD: begin
          if (i == '0 || qv > fbest) begin
            fbest <= qv;
          end
          i <= i + 1'b1;
          if (i + 1'b1 == cnt) begin
            fstat <= ST_OK;
            state <= S_EMIT;
          end else begin
            state <= S_Q_RD;
          end
        end
        S_F_RD: state <= (p == cnt) ? S_N_CHK : S_F_CMP;
        S_F_CMP: begin
          if ($signed(rdata.slope) < $signed(nl.slope)) begin
            p     <= p + 1'b1;
            state <= S_F_RD;
          end else if (rdata.slope == nl.slope) begin
            if ($signed(rdata.intercept) >= $signed(nl.intercept)) begin
              fstat <= ST_OK;
              state <= S_EMIT;
            end else begin
              j     <= p;
              ret   <= S_N_CHK;
              state <= S_RM_RD;
            end
          end else begin
            state <= S_N_CHK;
          end
        end
        S_N_CHK: begin
          if (p != '0 && p < cnt) begin
            fa0   <= AW'(p - 1'b1);
            fa1   <= p[AW-1:0];
            fkind <= FK_NEIGH;
            ret   <= S_N_DEC;
            state <= S_G_RD0;
          end else begin
            j     <= cnt;
            state <= S_IN_RD;
          end
        end
        S_RM_RD: begin
          if ({1'b0, j} + 1'b1 < {1'b0, cnt}) begin
            state <= S_RM_WR;
          end else begin
            cnt   <= cnt - 1'b1;
            state <= ret;
          end
        end
        S_RM_WR: begin
          j     <= j + 1'b1;
          state <= S_RM_RD;
        end
        S_G_RD0: begin
          unique case (fkind)
            FK_NEIGH: um <= nl;
            FK_RIGHT: ul <= nl;
            default:  ur <= nl;
          endcase
          state <= S_G_RD1;
        end
        S_G_RD1: begin
          if (fkind == FK_RIGHT) begin
            um <= rdata;
          end else begin
            ul <= rdata;
          end
          state <= S_G_GOT;
        end
        S_G_GOT: begin
          if (fkind == FK_LEFT) begin
            um <= rdata;
          end else begin
            ur <= rdata;
          end
          state <= S_U_DIFF;
        end
        S_U_DIFF: begin
          d1 <= $signed({ul.intercept[ICPT_W-1], ul.intercept})
              - $signed({um.intercept[ICPT_W-1], um.intercept});
          d2 <= $signed({um.intercept[ICPT_W-1], um.intercept})
              - $signed({ur.intercept[ICPT_W-1], ur.intercept});
          e1 <= $signed({ur.slope[SLOPE_W-1], ur.slope})
              - $signed({um.slope[SLOPE_W-1], um.slope});
          e2 <= $signed({um.slope[SLOPE_W-1], um.slope})
              - $signed({ul.slope[SLOPE_W-1], ul.slope});
          k     <= '0;
          state <= S_U_MUL;
        end
        S_U_MUL: begin
          mres <= mul_p;
          k    <= k + 1'b1;
          case (k)
            3'd1:    acc1 <= mres_w;
            3'd2:    acc1 <= acc1 + mres_hi;
            3'd3:    acc2 <= mres_w;
            3'd4:    acc2 <= acc2 + mres_hi;
            default: acc1 <= acc1;
          endcase
          if (k == 3'd4) begin
            state <= S_U_CMP;
          end
        end
        S_U_CMP: begin
          useless_f <= (acc1 >= acc2);
          state     <= ret;
        end
        S_N_DEC: begin
          if (useless_f) begin
            fstat <= ST_OK;
            state <= S_EMIT;
          end else begin
            j     <= cnt;
            state <= S_IN_RD;
          end
        end
        S_IN_RD: state <= (j > p) ? S_IN_WR : S_IN_PUT;
        S_IN_WR: begin
          j     <= j - 1'b1;
          state <= S_IN_RD;
        end
        S_IN_PUT: begin
          cnt   <= cnt + 1'b1;
          state <= S_R_CHK;
        end
        S_R_CHK: begin
          if ({1'b0, p} + 2'd2 < {1'b0, cnt}) begin
            fa0   <= AW'(p + 1'b1);
            fa1   <= AW'(p + 2'd2);
            fkind <= FK_RIGHT;
            ret   <= S_R_DEC;
            state <= S_G_RD0;
          end else begin
            state <= S_L_CHK;
          end
        end
        S_R_DEC: begin
          if (useless_f) begin
            j     <= p + 1'b1;
            ret   <= S_R_CHK;
            state <= S_RM_RD;
          end else begin
            state <= S_L_CHK;
          end
        end
        S_L_CHK: begin
          if (p >= CW'(2)) begin
            fa0   <= AW'(p - 2'd2);
            fa1   <= AW'(p - 1'b1);
            fkind <= FK_LEFT;
            ret   <= S_L_DEC;
            state <= S_G_RD0;
          end else begin
            fstat <= ST_OK;
            state <= S_EMIT;
          end
        end
        S_L_DEC: begin
          if (useless_f) begin
            j     <= p - 1'b1;
            p     <= p - 1'b1;
            ret   <= S_L_CHK;
            state <= S_RM_RD;
          end else begin
            fstat <= ST_OK;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!ov || results.ready) begin
            ov    <= 1'b1;
            obest <= fbest;
            ostat <= fstat;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/max_line_hull_container.sv =====
// Upper-envelope line store. Each request on "items" is an insert (mode 0:
// slope, intercept) or a query (mode 1: query_point); each request yields
// exactly one result on "results" with best_value and status (0 ok, 1 query
// on an empty store, 2 insert rejected because the store is full).
// Requests enter a two-deep queue, so the channel keeps accepting while the
// engine works or while a result waits in the output register.
// A query reads each stored line, multiplies it out at the query point and
// keeps the best value. An insert scans the stored lines below the new slope,
// moves lines one by one when a line is added or dropped, and runs each
// neighbour check on the shared cross-product multiplier. Rejections and
// empty queries go straight from idle to the result. Work is bounded by the
// line memory, which has one write port and one read port.
// Reset empties the store at once; no clearing pass is needed. When the
// receiver stalls, the finished result holds in the output register, the
// engine waits with its next result, and the queue fills, then stalls.
// Depends on mlh_pkg, mlh_if, mlh_front, mlh_engine and the macros header.
`include "max_line_hull_container_macros.svh"

module max_line_hull_container #(
  parameter int CAPACITY = 256
) (
  input  logic         clk,
  input  logic         rst,
  mlh_item_if.sink     items,
  mlh_result_if.source results
);
  import mlh_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic             cmd_valid;
  logic             cmd_ready;
  cmd_t             cmd;
  logic [CNT_W-1:0] line_count;

  mlh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  mlh_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .results    (results),
    .line_count (line_count)
  );

  `MLH_ASSERT(a_count_bound, 1'b1, line_count <= CNT_W'(CAPACITY), "line count over capacity")
  `MLH_ASSERT(a_zero_on_fail, results.valid && results.status != ST_OK, results.best_value == '0, "nonzero value with error status")
  `MLH_ASSERT(a_count_step, line_count != $past(line_count), line_count == $past(line_count) + 1'b1 || line_count == $past(line_count) - 1'b1, "line count jumped")
  `MLH_ASSERT_NEXT(a_idle_hold, cmd_ready && !cmd_valid, $stable(line_count), "line count moved while idle")

endmodule

// ===== tb/sv/max_line_hull_container_checker.sv =====
// Checker for the line hull container: watches both channels, keeps its own
// copy of the upper envelope, and compares every result with its prediction.
// Depends on mlh_pkg and the channel interfaces in mlh_if.
`timescale 1ns / 1ps

module max_line_hull_container_checker
  import mlh_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic   clk,
  input  logic   rst,
  mlh_item_if    items,
  mlh_result_if  results,
  output int     errors,
  output int     pending,
  output int     stored_lines
);

  typedef struct {
    longint  value;
    status_t status;
  } answer_t;

  answer_t answers_due[$];
  longint  env_slope[CAPACITY];
  longint  env_icpt[CAPACITY];
  int      env_count;

  // True when the middle line never rises above the envelope of its neighbors.
  function automatic bit is_covered(longint la, longint lb, longint ma, longint mb,
                                    longint ra, longint rb);
    logic signed [127:0] d1, d2, d3, d4;
    d1 = lb - mb;
    d2 = ra - ma;
    d3 = mb - rb;
    d4 = ma - la;
    return (d1 * d2) >= (d3 * d4);
  endfunction

  function automatic void drop_line(int p);
    for (int i = p; i + 1 < env_count; i++) begin
      env_slope[i] = env_slope[i+1];
      env_icpt[i]  = env_icpt[i+1];
    end
    env_count--;
  endfunction

  function automatic status_t add_line(longint a, longint b);
    int p;
    p = 0;
    if (env_count >= CAPACITY) return ST_FULL;
    while (p < env_count && env_slope[p] < a) p++;
    if (p < env_count && env_slope[p] == a) begin
      if (env_icpt[p] >= b) return ST_OK;
      drop_line(p);
    end
    if (p > 0 && p < env_count &&
        is_covered(env_slope[p-1], env_icpt[p-1], a, b, env_slope[p], env_icpt[p]))
      return ST_OK;
    for (int i = env_count; i > p; i--) begin
      env_slope[i] = env_slope[i-1];
      env_icpt[i]  = env_icpt[i-1];
    end
    env_slope[p] = a;
    env_icpt[p]  = b;
    env_count++;
    while (p + 2 < env_count &&
           is_covered(env_slope[p], env_icpt[p], env_slope[p+1], env_icpt[p+1],
                      env_slope[p+2], env_icpt[p+2]))
      drop_line(p + 1);
    while (p >= 2 &&
           is_covered(env_slope[p-2], env_icpt[p-2], env_slope[p-1], env_icpt[p-1],
                      env_slope[p], env_icpt[p])) begin
      drop_line(p - 1);
      p--;
    end
    return ST_OK;
  endfunction

  function automatic answer_t serve_request(logic mode, logic signed [31:0] slope,
                                            logic signed [47:0] icpt,
                                            logic signed [31:0] point);
    answer_t r;
    longint  x, v;
    r.value = 0;
    if (op_t'(mode) == OP_INSERT) begin
      r.status = add_line(longint'(slope), longint'(icpt));
    end else if (env_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      x = longint'(point);
      r.value = env_slope[0] * x + env_icpt[0];
      for (int i = 1; i < env_count; i++) begin
        v = env_slope[i] * x + env_icpt[i];
        if (v > r.value) r.value = v;
      end
      r.status = ST_OK;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t got, want;
    if (rst) begin
      env_count = 0;
      answers_due.delete();
      errors = 0;
    end else begin
      if (results.valid && results.ready) begin
        got.value  = results.best_value;
        got.status = results.status;
        if (answers_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value=%0d status=%0d",
                   $time, got.value, got.status);
        end else begin
          want = answers_due.pop_front();
          if (got.value !== want.value) begin
            errors++;
            $display("%0t: best_value expected %0d actual %0d",
                     $time, want.value, got.value);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, got.status);
          end
        end
      end
      if (items.valid && items.ready)
        answers_due.push_back(serve_request(items.mode, items.slope, items.intercept,
                                            items.query_point));
    end
    pending      = answers_due.size();
    stored_lines = env_count;
  end

endmodule

// ===== tb/sv/max_line_hull_container_tb.sv =====
// Top of the line hull container testbench: clock, reset, request stimulus,
// result back-pressure and the verdict.
// Depends on mlh_pkg, mlh_if, the block and max_line_hull_container_checker.
`timescale 1ns / 1ps

module max_line_hull_container_tb;
  import mlh_pkg::*;

  localparam int CAPACITY   = 256;
  localparam int RUN_LIMIT  = 8000000;
  localparam int END_CYCLES = 1000;

  logic clk;
  logic rst;
  int   errors, pending, stored_lines;
  int   send_idle_pct, recv_idle_pct;
  int   recv_hold;
  bit   hold_go;
  bit   hold_used;
  int   cycle_count;

  mlh_item_if   items();
  mlh_result_if results();

  max_line_hull_container #(.CAPACITY(CAPACITY)) u_top (
    .clk(clk),
    .rst(rst),
    .items(items),
    .results(results)
  );

  max_line_hull_container_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk(clk),
    .rst(rst),
    .items(items),
    .results(results),
    .errors(errors),
    .pending(pending),
    .stored_lines(stored_lines)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Long receiver hold-off, started once by the stimulus.
  always @(posedge clk) begin
    if (rst) begin
      recv_hold <= 0;
      hold_used <= 1'b0;
    end else if (hold_go && !hold_used) begin
      recv_hold <= 400;
      hold_used <= 1'b1;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
    end
  end

  // Result back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else if (recv_hold > 0) begin
      results.ready <= 1'b0;
    end else begin
      results.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("max_line_hull_container_tb: FAIL");
      $finish;
    end
  end

  task automatic send_request(op_t op, logic [31:0] slope, logic [47:0] icpt,
                              logic [31:0] point);
    while ($urandom_range(99) < send_idle_pct) begin
      items.valid <= 1'b0;
      @(posedge clk);
    end
    items.valid       <= 1'b1;
    items.mode        <= op;
    items.slope       <= slope;
    items.intercept   <= icpt;
    items.query_point <= point;
    do @(posedge clk); while (!items.ready);
  endtask

  task automatic send_line(longint a, longint b);
    send_request(OP_INSERT, a[31:0], b[47:0], $urandom);
  endtask

  task automatic send_query(longint x);
    send_request(OP_QUERY, $urandom, 48'({$urandom, $urandom}), x[31:0]);
  endtask

  task automatic wait_drained();
    items.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_slope();
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($urandom_range(2000)) - 32'd1000;
    endcase
  endfunction

  function automatic logic [47:0] pick_icpt();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1:    return r[47:0];
      2:       return $urandom_range(1) ? 48'h8000_0000_0000 : 48'h7fff_ffff_ffff;
      default: return 48'($urandom_range(2000000)) - 48'd1000000;
    endcase
  endfunction

  function automatic logic [31:0] pick_point();
    case ($urandom_range(5))
      0, 1:    return $urandom;
      2:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($urandom_range(20000)) - 32'd10000;
    endcase
  endfunction

  initial begin
    longint k;
    rst = 1'b1;
    hold_go = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items.valid = 1'b0;
    items.mode = 1'b0;
    items.slope = '0;
    items.intercept = '0;
    items.query_point = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty query, equal slopes, a line touching the envelope at a
    // point, a covered line, extremes of every field.
    send_query(0);
    send_line(-1, 0);
    send_line(1, 0);
    send_line(0, 0);
    send_line(0, -5);
    send_line(1, -3);
    send_line(1, 4);
    send_line(0, 3);
    send_line(0, 2);
    send_query(0);
    send_query(-2147483648);
    send_query(2147483647);
    send_line(-2147483648, 140737488355327);
    send_line(2147483647, -140737488355328);
    send_line(2147483647, 140737488355327);
    send_line(-2147483648, -140737488355328);
    send_query(-2147483648);
    send_query(2147483647);
    send_query(12345);
    send_request(OP_QUERY, 32'hffff_ffff, 48'hffff_ffff_ffff, 32'hffff_ffff);
    send_request(OP_INSERT, 32'h5555_5555, 48'haaaa_aaaa_aaaa, 32'hffff_ffff);
    send_query(-1);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 70 : 0;
      recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 28 : 0;
      for (int n = 0; n < 410; n++) begin
        if (phase == 0 && n == 100) hold_go <= 1'b1;
        if (phase == 0 && n == 250) wait_drained();
        if ($urandom_range(99) < 55) send_request(OP_INSERT, pick_slope(), pick_icpt(),
                                                  $urandom);
        else send_request(OP_QUERY, $urandom, 48'({$urandom, $urandom}), pick_point());
      end
    end

    // Fill the store with lines along a parabola, then check the full store.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < 600 && stored_lines < CAPACITY; n++) begin
      k = (n % CAPACITY) - CAPACITY / 2;
      send_line(k, 140737488355327 - k * k * 1000 - n / CAPACITY);
      if (n % 32 == 31) wait_drained();
    end
    wait_drained();
    send_line(5, 140737488355327);
    send_line(100000, 0);
    send_query(0);
    send_query(-5000);
    send_query(5000);

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("max_line_hull_container_tb: PASS");
    end else begin
      $display("max_line_hull_container_tb: FAIL");
    end
    $finish;
  end

endmodule
